FILE: rtl/xlsa_pkg.sv
// Shared types, operation and condition codes and width helpers for the logic/shift ALU.
package xlsa_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned OpW    = 4;
    localparam int unsigned WselW  = 2;
    localparam int unsigned CondW  = 4;
    localparam int unsigned CountW = 5;

    // Operation codes.
    localparam logic [OpW-1:0] OP_AND   = 4'd0;
    localparam logic [OpW-1:0] OP_TEST  = 4'd1;
    localparam logic [OpW-1:0] OP_OR    = 4'd2;
    localparam logic [OpW-1:0] OP_XOR   = 4'd3;
    localparam logic [OpW-1:0] OP_NOT   = 4'd4;
    localparam logic [OpW-1:0] OP_SHL   = 4'd5;
    localparam logic [OpW-1:0] OP_SHR   = 4'd6;
    localparam logic [OpW-1:0] OP_SAR   = 4'd7;
    localparam logic [OpW-1:0] OP_SETCC = 4'd8;

    // Operand width codes; the unused code behaves as a doubleword.
    localparam logic [WselW-1:0] WSEL_BYTE  = 2'd0;
    localparam logic [WselW-1:0] WSEL_WORD  = 2'd1;
    localparam logic [WselW-1:0] WSEL_DWORD = 2'd2;

    // Condition pairs, selected by the upper three bits of the condition code.
    // The lowest bit of the code inverts the tested condition.
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_E  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    typedef struct packed {
        logic cf;
        logic pf;
        logic zf;
        logic sf;
        logic of;
    } t_flags;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [WselW-1:0] width_sel;
        logic [DataW-1:0] dest_value;
        logic [DataW-1:0] src_value;
        logic [CondW-1:0] cond_code;
        t_flags           flags;
    } t_item;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             write_back;
        t_flags           flags;
    } t_result;

    function automatic logic [DataW-1:0] width_mask(input logic [WselW-1:0] ws);
        logic [DataW-1:0] m;
        case (ws)
            WSEL_BYTE: m = 32'h0000_00ff;
            WSEL_WORD: m = 32'h0000_ffff;
            default:   m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [DataW-1:0] sign_mask(input logic [WselW-1:0] ws);
        logic [DataW-1:0] m;
        case (ws)
            WSEL_BYTE: m = 32'h0000_0080;
            WSEL_WORD: m = 32'h0000_8000;
            default:   m = 32'h8000_0000;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/xlsa_exec.sv
// Combinational execution of one logic, shift or SETcc instruction.
module xlsa_exec
    import xlsa_pkg::*;
(
    input  t_item   i_item,
    output t_result o_result
);

    logic [DataW-1:0]  mask;
    logic [DataW-1:0]  sbit;
    logic [DataW-1:0]  d;
    logic [DataW-1:0]  s;
    logic [CountW-1:0] cnt;
    logic [DataW-1:0]  ext;
    logic [DataW-1:0]  sar_val;
    logic              cond_base;
    logic              cond_true;
    logic              is_logic;
    logic [DataW-1:0]  res;
    logic              wb;

    assign mask = width_mask(i_item.width_sel);
    assign sbit = sign_mask(i_item.width_sel);
    assign d    = i_item.dest_value & mask;
    assign s    = i_item.src_value & mask;
    assign cnt  = i_item.src_value[CountW-1:0];

    // Sign-extend to the full word so that an arithmetic shift fills with the right bit.
    assign ext     = ((d & sbit) != '0) ? (d | ~mask) : d;
    assign sar_val = DataW'($signed(ext) >>> cnt) & mask;

    always_comb begin
        case (i_item.cond_code[CondW-1:1])
            CC_O:    cond_base = i_item.flags.of;
            CC_B:    cond_base = i_item.flags.cf;
            CC_E:    cond_base = i_item.flags.zf;
            CC_BE:   cond_base = i_item.flags.cf | i_item.flags.zf;
            CC_S:    cond_base = i_item.flags.sf;
            CC_P:    cond_base = i_item.flags.pf;
            CC_L:    cond_base = i_item.flags.sf ^ i_item.flags.of;
            CC_LE:   cond_base = i_item.flags.zf | (i_item.flags.sf ^ i_item.flags.of);
            default: cond_base = 1'b0;
        endcase
    end

    assign cond_true = cond_base ^ i_item.cond_code[0];

    always_comb begin
        res      = d;
        wb       = 1'b1;
        is_logic = 1'b0;
        case (i_item.op)
            OP_AND: begin
                res      = d & s;
                is_logic = 1'b1;
            end
            OP_TEST: begin
                res      = d & s;
                wb       = 1'b0;
                is_logic = 1'b1;
            end
            OP_OR: begin
                res      = d | s;
                is_logic = 1'b1;
            end
            OP_XOR: begin
                res      = d ^ s;
                is_logic = 1'b1;
            end
            OP_NOT:   res = ~d & mask;
            OP_SHL:   res = (d << cnt) & mask;
            OP_SHR:   res = d >> cnt;
            OP_SAR:   res = sar_val;
            OP_SETCC: res = {{(DataW-1){1'b0}}, cond_true};
            default: begin
                res = d;
                wb  = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_result.value      = res;
        o_result.write_back = wb;
        o_result.flags      = i_item.flags;
        if (is_logic) begin
            o_result.flags.cf = 1'b0;
            o_result.flags.of = 1'b0;
            o_result.flags.zf = (res == '0);
            o_result.flags.sf = ((res & sbit) != '0);
        end
    end

endmodule

FILE: rtl/x86_logic_shift_alu_flags_unit.sv
// Top level of the x86 logic, shift and SETcc ALU with flag update.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | into unit | i_in_valid / o_in_stall   | op, width, operands, condition, flags
//  out     | from unit | o_out_valid / i_out_stall | result, write-back, updated flags
//
// Each word passes an input register, one level of combinational execution logic and a
// result register, from which the output side takes it.
// One word is accepted every cycle while the output side keeps taking results, because each
// register can hand on its word and take a new one in the same cycle.
// The reset is synchronous and active low; it clears only the two valid bits.
// When the output is stalled the result register holds, the input register fills behind it,
// and only then is the input channel stalled.
module x86_logic_shift_alu_flags_unit
    import xlsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [OpW-1:0]   i_op,
    input  logic [WselW-1:0] i_width_sel,
    input  logic [DataW-1:0] i_dest_value,
    input  logic [DataW-1:0] i_src_value,
    input  logic [CondW-1:0] i_cond_code,
    input  logic             i_cf_in,
    input  logic             i_pf_in,
    input  logic             i_zf_in,
    input  logic             i_sf_in,
    input  logic             i_of_in,

    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [DataW-1:0] o_result_value,
    output logic             o_write_back,
    output logic             o_cf_out,
    output logic             o_pf_out,
    output logic             o_zf_out,
    output logic             o_sf_out,
    output logic             o_of_out
);

    // Input register: holds the accepted word until the result register can take it.
    logic    r_in_valid;
    t_item   r_in;
    // Result register: holds the finished result until the output side takes it.
    logic    r_out_valid;
    t_result r_out;

    t_item   in_word;
    t_result exec_result;
    logic    out_adv;
    logic    in_adv;

    assign in_word.op         = i_op;
    assign in_word.width_sel  = i_width_sel;
    assign in_word.dest_value = i_dest_value;
    assign in_word.src_value  = i_src_value;
    assign in_word.cond_code  = i_cond_code;
    assign in_word.flags.cf   = i_cf_in;
    assign in_word.flags.pf   = i_pf_in;
    assign in_word.flags.zf   = i_zf_in;
    assign in_word.flags.sf   = i_sf_in;
    assign in_word.flags.of   = i_of_in;

    // The result register moves whenever it is empty or its word is being taken; the input
    // register moves whenever it is empty or its word moves on into the result register.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_adv     = !r_in_valid || out_adv;
    assign o_in_stall = !in_adv;

    xlsa_exec u_exec (
        .i_item   (r_in),
        .o_result (exec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset; they load only when a valid word moves in.
    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in <= in_word;
        end
        if (out_adv && r_in_valid) begin
            r_out <= exec_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out.value;
    assign o_write_back   = r_out.write_back;
    assign o_cf_out       = r_out.flags.cf;
    assign o_pf_out       = r_out.flags.pf;
    assign o_zf_out       = r_out.flags.zf;
    assign o_sf_out       = r_out.flags.sf;
    assign o_of_out       = r_out.flags.of;

    // The input side is only ever stalled while a word sits in the input register.
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // Parity passes straight through the execution logic.
    a_pf_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_in_valid) |=> (r_out.flags.pf == $past(r_in.flags.pf)))
        else $error("parity flag altered");

    // Logic operations clear carry and overflow.
    a_logic_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_in_valid && (r_in.op == OP_AND || r_in.op == OP_TEST ||
                                   r_in.op == OP_OR || r_in.op == OP_XOR))
        |=> (!r_out.flags.cf && !r_out.flags.of))
        else $error("logic operation left carry or overflow set");

    // SETcc produces a single bit and writes it back.
    a_setcc_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_in_valid && r_in.op == OP_SETCC)
        |=> (r_out.value[DataW-1:1] == '0 && r_out.write_back))
        else $error("SETcc result is not a single written bit");

endmodule

FILE: tb/sv/x86_logic_shift_alu_flags_unit_tb.sv
// Self-checking testbench for the x86 logic, shift and SETcc ALU with flag update.
module x86_logic_shift_alu_flags_unit_tb;
    import xlsa_pkg::*;

    // A generous limit: several times what the slowest correct run needs.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_WORDS = 1950;
    // The result register sits two stages behind the input; spare cycles at the end
    // catch any result that should not be there.
    localparam int unsigned DRAIN_CYCLES = 6;

    // Codes the block does not define: the lowest and top undefined operation codes and the unused width code.
    localparam logic [OpW-1:0]   OP_UNDEF_TOP  = 4'd15;
    localparam logic [OpW-1:0]   OP_UNDEF_LOW  = 4'd9;
    localparam logic [WselW-1:0] WSEL_UNUSED   = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [OpW-1:0]   i_op;
    logic [WselW-1:0] i_width_sel;
    logic [DataW-1:0] i_dest_value;
    logic [DataW-1:0] i_src_value;
    logic [CondW-1:0] i_cond_code;
    logic             i_cf_in;
    logic             i_pf_in;
    logic             i_zf_in;
    logic             i_sf_in;
    logic             i_of_in;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [DataW-1:0] o_result_value;
    logic             o_write_back;
    logic             o_cf_out;
    logic             o_pf_out;
    logic             o_zf_out;
    logic             o_sf_out;
    logic             o_of_out;

    // Results still owed by the block, oldest first.
    t_result     owed_results[$];
    int unsigned error_count = 0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;

    // Largest random gap on either side; zero gives stretches of back-to-back traffic.
    int unsigned in_idle_max = 11;
    int unsigned out_idle_max = 11;

    x86_logic_shift_alu_flags_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_width_sel    (i_width_sel),
        .i_dest_value   (i_dest_value),
        .i_src_value    (i_src_value),
        .i_cond_code    (i_cond_code),
        .i_cf_in        (i_cf_in),
        .i_pf_in        (i_pf_in),
        .i_zf_in        (i_zf_in),
        .i_sf_in        (i_sf_in),
        .i_of_in        (i_of_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_write_back   (o_write_back),
        .o_cf_out       (o_cf_out),
        .o_pf_out       (o_pf_out),
        .o_zf_out       (o_zf_out),
        .o_sf_out       (o_sf_out),
        .o_of_out       (o_of_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Works out what the block must return for one instruction word. The block carries no
    // state from one word to the next, so each word stands on its own.
    function automatic t_result alu_expect(input t_item w);
        logic [DataW-1:0]        mask;
        logic [DataW-1:0]        sbit;
        logic [DataW-1:0]        d;
        logic [DataW-1:0]        s;
        logic [DataW-1:0]        r;
        logic signed [DataW-1:0] sext;
        logic [CountW-1:0]       cnt;
        logic                    cond;
        logic                    is_logic;
        t_result                 e;

        // The unused width code behaves as a doubleword.
        case (w.width_sel)
            WSEL_BYTE: begin
                mask = 32'h0000_00ff;
                sbit = 32'h0000_0080;
            end
            WSEL_WORD: begin
                mask = 32'h0000_ffff;
                sbit = 32'h0000_8000;
            end
            default: begin
                mask = 32'hffff_ffff;
                sbit = 32'h8000_0000;
            end
        endcase
        d = w.dest_value & mask;
        s = w.src_value & mask;
        // The count comes from the raw source, before width masking.
        cnt = w.src_value[CountW-1:0];
        e.flags = w.flags;
        e.write_back = 1'b1;
        is_logic = 1'b0;
        r = d;

        case (w.op)
            OP_AND: begin
                r = d & s;
                is_logic = 1'b1;
            end
            OP_TEST: begin
                r = d & s;
                is_logic = 1'b1;
                e.write_back = 1'b0;
            end
            OP_OR: begin
                r = d | s;
                is_logic = 1'b1;
            end
            OP_XOR: begin
                r = d ^ s;
                is_logic = 1'b1;
            end
            OP_NOT: r = ~d & mask;
            OP_SHL: r = (d << cnt) & mask;
            OP_SHR: r = d >> cnt;
            OP_SAR: begin
                // Widen the operand's sign to 32 bits, shift arithmetically, then trim.
                sext = ((d & sbit) != 0) ? (d | ~mask) : d;
                sext = sext >>> cnt;
                r = sext & mask;
            end
            OP_SETCC: begin
                case (w.cond_code[3:1])
                    CC_O:    cond = w.flags.of;
                    CC_B:    cond = w.flags.cf;
                    CC_E:    cond = w.flags.zf;
                    CC_BE:   cond = w.flags.cf | w.flags.zf;
                    CC_S:    cond = w.flags.sf;
                    CC_P:    cond = w.flags.pf;
                    CC_L:    cond = w.flags.sf ^ w.flags.of;
                    default: cond = w.flags.zf | (w.flags.sf ^ w.flags.of);
                endcase
                r = {{(DataW-1){1'b0}}, cond ^ w.cond_code[0]};
            end
            default: begin
                // Undefined operations return the trimmed destination, write nothing back and keep the flags.
                r = d;
                e.write_back = 1'b0;
            end
        endcase

        if (is_logic) begin
            e.flags.cf = 1'b0;
            e.flags.of = 1'b0;
            e.flags.zf = (r == 0);
            e.flags.sf = ((r & sbit) != 0);
        end
        e.value = r;
        return e;
    endfunction

    function automatic t_item make_word(input logic [OpW-1:0] op, input logic [WselW-1:0] ws,
                                        input logic [DataW-1:0] d, input logic [DataW-1:0] s,
                                        input logic [CondW-1:0] cc, input logic [4:0] fl);
        t_item w;
        w.op = op;
        w.width_sel = ws;
        w.dest_value = d;
        w.src_value = s;
        w.cond_code = cc;
        w.flags = fl;
        return w;
    endfunction

    // Operands lean towards the values where flags and sign extension change behaviour.
    function automatic logic [DataW-1:0] pick_operand();
        logic [DataW-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h0000_0000;
            1:       v = 32'hffff_ffff;
            2:       v = ($urandom_range(0, 1) != 0) ? 32'h0000_0080 : 32'h8000_0000;
            3:       v = ($urandom_range(0, 1) != 0) ? 32'h0000_8000 : 32'h7fff_ffff;
            4:       v = $urandom_range(0, 255);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_item random_word();
        t_item w;
        logic [4:0] counts [6];
        counts = '{5'd0, 5'd7, 5'd8, 5'd15, 5'd16, 5'd31};
        // Mostly defined operations; a small share of the undefined codes.
        if ($urandom_range(0, 19) != 0)
            w.op = OpW'($urandom_range(OP_AND, OP_SETCC));
        else
            w.op = OpW'($urandom_range(OP_UNDEF_LOW, OP_UNDEF_TOP));
        w.width_sel = WselW'($urandom_range(WSEL_BYTE, WSEL_UNUSED));
        w.dest_value = pick_operand();
        w.src_value = pick_operand();
        // Now and then pin the shift count on a width boundary.
        if ($urandom_range(0, 3) == 0)
            w.src_value[CountW-1:0] = counts[$urandom_range(0, 5)];
        w.cond_code = CondW'($urandom_range(0, 15));
        w.flags = 5'($urandom_range(0, 31));
        return w;
    endfunction

    // Drives one word after a random gap and waits until the block takes it. It is entered
    // and left just after a rising edge, so valid is only lowered when a gap is drawn and
    // is never lowered and raised within one step.
    task automatic send_word(input t_item w);
        int unsigned gap;
        gap = (in_idle_max == 0) ? 0 : $urandom_range(0, in_idle_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op         <= w.op;
        i_width_sel  <= w.width_sel;
        i_dest_value <= w.dest_value;
        i_src_value  <= w.src_value;
        i_cond_code  <= w.cond_code;
        i_cf_in      <= w.flags.cf;
        i_pf_in      <= w.flags.pf;
        i_zf_in      <= w.flags.zf;
        i_sf_in      <= w.flags.sf;
        i_of_in      <= w.flags.of;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        owed_results.push_back(alu_expect(w));
        words_sent++;
    endtask

    // Logic operations: zero and sign results, the width trim of wide operands, TEST.
    task automatic test_logic_ops();
        send_word(make_word(OP_AND,  WSEL_BYTE,  32'hdead_beff, 32'h1234_56ff, 4'd0, 5'h1f));
        send_word(make_word(OP_TEST, WSEL_DWORD, 32'h8000_0000, 32'hffff_ffff, 4'd0, 5'h00));
        send_word(make_word(OP_OR,   WSEL_WORD,  32'hffff_0000, 32'h00ff_0000, 4'd0, 5'h1f));
        send_word(make_word(OP_XOR,  WSEL_DWORD, 32'hffff_ffff, 32'hffff_ffff, 4'd0, 5'h15));
    endtask

    // NOT and the shifts: counts of zero and at the operand width, sign fill, and the
    // unused width code.
    task automatic test_not_and_shifts();
        send_word(make_word(OP_NOT, WSEL_BYTE,   32'hffff_ff5a, 32'h0000_0000, 4'd0, 5'h0a));
        send_word(make_word(OP_SHL, WSEL_WORD,   32'h0001_8001, 32'hffff_ffe0, 4'd0, 5'h11));
        send_word(make_word(OP_SHL, WSEL_DWORD,  32'h0000_0001, 32'h0000_001f, 4'd0, 5'h00));
        send_word(make_word(OP_SHR, WSEL_BYTE,   32'h0000_00ff, 32'h0000_0008, 4'd0, 5'h1f));
        send_word(make_word(OP_SAR, WSEL_BYTE,   32'h0000_0080, 32'h0000_0007, 4'd0, 5'h00));
        send_word(make_word(OP_SAR, WSEL_WORD,   32'h0000_7fff, 32'h0000_0010, 4'd0, 5'h00));
        send_word(make_word(OP_SAR, WSEL_UNUSED, 32'h8000_0000, 32'h0000_001f, 4'd0, 5'h1f));
    endtask

    // Every SETcc condition, with random incoming flags, and one undefined operation.
    task automatic test_setcc_conditions();
        for (int unsigned cc = 0; cc < 16; cc++)
            send_word(make_word(OP_SETCC, WselW'($urandom_range(0, 3)), $urandom, $urandom,
                                CondW'(cc), 5'($urandom_range(0, 31))));
        send_word(make_word(OP_UNDEF_TOP, WSEL_WORD, 32'hcafe_f00d, 32'h0, 4'd0, 5'h1b));
    endtask

    // The random bulk, in phases that switch the idling on each side on and off.
    task automatic test_random_traffic(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 250 == 0) begin
                case ((i / 250) % 4)
                    0: begin in_idle_max = 11; out_idle_max = 11; end
                    1: begin in_idle_max = 0;  out_idle_max = 0;  end
                    2: begin in_idle_max = 11; out_idle_max = 0;  end
                    default: begin in_idle_max = 0; out_idle_max = 11; end
                endcase
            end
            send_word(random_word());
        end
    endtask

    // Stall on the output side: for each result a random hold of up to out_idle_max is drawn,
    // then the stall is released until that result has been taken.
    initial begin : out_stall_gen
        int unsigned hold;
        i_out_stall = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = (out_idle_max == 0) ? 0 : $urandom_range(0, out_idle_max);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic check_field(input string name, input logic [DataW-1:0] want,
                               input logic [DataW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    // Every result taken at an edge is compared with the oldest word still owed.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                $error("result %0h arrived with nothing owed", o_result_value);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                check_field("result_value", want.value, o_result_value);
                check_field("write_back", DataW'(want.write_back), DataW'(o_write_back));
                check_field("cf_out", DataW'(want.flags.cf), DataW'(o_cf_out));
                check_field("pf_out", DataW'(want.flags.pf), DataW'(o_pf_out));
                check_field("zf_out", DataW'(want.flags.zf), DataW'(o_zf_out));
                check_field("sf_out", DataW'(want.flags.sf), DataW'(o_sf_out));
                check_field("of_out", DataW'(want.flags.of), DataW'(o_of_out));
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("x86_logic_shift_alu_flags_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_AND;
        i_width_sel  = WSEL_BYTE;
        i_dest_value = '0;
        i_src_value  = '0;
        i_cond_code  = '0;
        i_cf_in      = 1'b0;
        i_pf_in      = 1'b0;
        i_zf_in      = 1'b0;
        i_sf_in      = 1'b0;
        i_of_in      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_logic_ops();
        test_not_and_shifts();
        test_setcc_conditions();
        test_random_traffic(RANDOM_WORDS);

        // Lower valid once the last word is in, let the pipeline empty, then wait DRAIN_CYCLES
        // more for any stray result to show itself.
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words across all nine operations, undefined codes and every width;",
                 words_sent);
        $display("compared %0d results field by field, with idling on both sides.",
                 results_seen);
        if (error_count == 0)
            $display("x86_logic_shift_alu_flags_unit_tb: clean");
        else
            $display("x86_logic_shift_alu_flags_unit_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/xlsa_pkg.sv
rtl/xlsa_exec.sv
rtl/x86_logic_shift_alu_flags_unit.sv
tb/sv/x86_logic_shift_alu_flags_unit_tb.sv
